// ----- sv/trial_division_next_prime_assert.svh -----
// assertion macros for the trial division prime block
// expects clk and rst_n in the scope where a macro is used
`ifndef TRIAL_DIVISION_NEXT_PRIME_ASSERT_SVH
`define TRIAL_DIVISION_NEXT_PRIME_ASSERT_SVH

// same-cycle implication, off while in reset
`define TDNP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define TDNP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tdnp_pkg.sv -----
// package for the trial division prime block: widths, command codes, sequencer states
// no dependencies
package tdnp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IO_W        = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  localparam logic CMD_TEST = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } tdnp_state_t;

endpackage

// ----- sv/trial_division_next_prime.sv -----
// trial division primality test and next-prime search; uses tdnp_pkg and the assert macros
// each candidate gets a check, then trial division by odd divisors from three upward
// each divisor runs on the shared restoring divider (one bit per cycle)
// throughput: one item at a time, in_ready high only while idle
// reset: synchronous active-low rst_n clears the sequencer and the output valid
`include "trial_division_next_prime_assert.svh"

module trial_division_next_prime (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [tdnp_pkg::IO_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [tdnp_pkg::IO_W-1:0] out_result_value,
  output logic                     out_prime_flag,
  output logic                     out_overflow
);

  import tdnp_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam logic [VW-1:0] VAL_MAX = '1;

  // sequencer
  tdnp_state_t state_r, state_nxt;

  // candidate, divisor and divider registers
  logic          cmd_r,   cmd_nxt;
  logic [VW-1:0] n_r,     n_nxt;
  logic [VW-1:0] d_r,     d_nxt;
  logic [VW-1:0] rem_r,   rem_nxt;
  logic [VW-1:0] quo_r,   quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic          pflag_r, pflag_nxt;
  logic          ovf_r,   ovf_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [IO_W-1:0] out_value_r, out_value_nxt;
  logic          out_prime_r, out_prime_nxt;
  logic          out_ovf_r,   out_ovf_nxt;

  logic in_xfer;
  logic out_free;

  // shared divider step: shift in next dividend bit, trial subtract
  logic [VW:0] trial;
  logic [VW:0] trial_diff;
  logic        trial_ge;

  // candidate classification
  logic n_le1, n_is2, n_even, at_top;
  logic bound_pass, rem_zero;
  logic chk_comp, chk_prime, ev_comp, ev_prime;
  logic composite, found, step_on;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign trial      = {rem_r, quo_r[VW-1]};
  assign trial_ge   = (trial >= {1'b0, d_r});
  assign trial_diff = trial - {1'b0, d_r};

  assign n_le1  = (n_r <= VW'(1));
  assign n_is2  = (n_r == VW'(2));
  assign n_even = !n_r[0];
  // next odd candidate would pass the top of the range
  assign at_top = (n_r > (VAL_MAX - VW'(2)));

  // loop ends once d > n / d; d is only stepped while d <= n / d, so d + 2 cannot wrap
  assign bound_pass = (d_r > quo_r);
  assign rem_zero   = (rem_r == '0);

  assign chk_prime = (state_r == ST_CHECK) && n_is2;
  assign chk_comp  = (state_r == ST_CHECK) && (n_le1 || (n_even && !n_is2));
  assign ev_prime  = (state_r == ST_EVAL) && bound_pass;
  assign ev_comp   = (state_r == ST_EVAL) && !bound_pass && rem_zero;
  assign found     = chk_prime || ev_prime;
  assign composite = chk_comp || ev_comp;
  // composite under a next command moves on to the next odd candidate unless at the top of the range
  assign step_on   = composite && (cmd_r == CMD_NEXT) && !at_top;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_CHECK;
      end
      ST_CHECK, ST_EVAL: begin
        if (found) begin
          state_nxt = ST_DONE;
        end else if (composite) begin
          state_nxt = step_on ? ST_CHECK : ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_EVAL;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    cmd_nxt       = cmd_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    pflag_nxt     = pflag_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_prime_nxt = out_prime_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt   = in_command;
          // next command starts from an odd value: setting the lsb raises an even one by one
          n_nxt     = VW'(in_value) | VW'(in_command == CMD_NEXT);
          pflag_nxt = 1'b0;
          ovf_nxt   = 1'b0;
        end
      end
      ST_CHECK, ST_EVAL: begin
        if (found) begin
          pflag_nxt = 1'b1;
        end else if (composite) begin
          pflag_nxt = 1'b0;
          if (step_on) begin
            n_nxt = n_r + VW'(2);
          end else if (cmd_r == CMD_NEXT) begin
            // search ran off the top
            n_nxt   = '0;
            ovf_nxt = 1'b1;
          end
        end else begin
          // start a division of n by the next odd divisor
          d_nxt   = (state_r == ST_CHECK) ? VW'(3) : d_r + VW'(2);
          rem_nxt = '0;
          quo_nxt = n_r;
          cnt_nxt = CNT_W'(VW - 1);
        end
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? trial_diff[VW-1:0] : trial[VW-1:0];
        quo_nxt = {quo_r[VW-2:0], trial_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = IO_W'(n_r);
          out_prime_nxt = pflag_r;
          out_ovf_nxt   = ovf_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    pflag_r     <= pflag_nxt;
    ovf_r       <= ovf_nxt;
    out_value_r <= out_value_nxt;
    out_prime_r <= out_prime_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_prime_flag   = out_prime_r;
  assign out_overflow     = out_ovf_r;

  // only odd candidates above two reach the divider, with an odd divisor from three
  `TDNP_ASSERT_IMP(a_div_odd, (state_r == ST_DIV),
    (n_r[0] && d_r[0] && (d_r >= VW'(3))), "divider running on even operand or small divisor")
  // an accepted item always starts with a candidate check
  `TDNP_ASSERT_NXT(a_start_check, in_xfer, (state_r == ST_CHECK),
    "accepted item did not enter the check state")
  // an overflow result carries a zero value and no prime flag
  `TDNP_ASSERT_IMP(a_ovf_result, (out_valid_r && out_ovf_r),
    (!out_prime_r && (out_value_r == '0)), "overflow result with nonzero value or prime flag")
  // the output register is only loaded when it is free
  `TDNP_ASSERT_NXT(a_no_overwrite, (out_valid_r && !out_ready),
    ($stable(out_value_r) && out_valid_r), "pending result overwritten")

endmodule
